FILE: rtl/core/line_sensor_window_drive_top_macros.svh
// Assertion macros for the line sensor window drive checker.
// Depends on the clock aclk and the active-low reset aresetn in scope.
`ifndef LINE_SENSOR_WINDOW_DRIVE_TOP_MACROS_SVH
`define LINE_SENSOR_WINDOW_DRIVE_TOP_MACROS_SVH

// property checked outside reset
`define LSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define LSW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/lsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the line sensor window drive block.
// No dependencies.
package lsw_pkg;

    localparam int CHANNELS  = 8;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 19;
    localparam int WIN_W     = SAMPLE_W + 2;
    localparam int DUTY_W    = 12;
    localparam int DIR_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CH6_IDX   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_BELOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ABOVE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ABOVE_CH6 = 2'd2;

    localparam logic [SAMPLE_W-1:0] MARGIN_BELOW_RST     = 12'd100;
    localparam logic [SAMPLE_W-1:0] MARGIN_ABOVE_RST     = 12'd100;
    localparam logic [SAMPLE_W-1:0] MARGIN_ABOVE_CH6_RST = 12'd120;

    localparam logic [DIR_W-1:0] DRIVE_DIR = 4'd12;
    localparam logic [DIR_W-1:0] STOP_DIR  = 4'd0;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_d;
        logic [DIR_W-1:0]  direction;
        logic              stop;
    } drive_t;

    typedef struct packed {
        logic acc;
        logic divide;
    } lane_ctrl_t;

    localparam drive_t DRIVE_STOP = '{
        duty_a: '0, duty_b: '0, duty_c: '0, duty_d: '0,
        direction: STOP_DIR, stop: 1'b1
    };

endpackage

FILE: rtl/core/lsw_lane.sv
`timescale 1ns / 1ps
// One sensor channel: calibration sum, centre by reciprocal multiply,
// and the signed window compare. Depends on lsw_pkg.
module lsw_lane #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsw_pkg::lane_ctrl_t           ctrl,
    input  logic [lsw_pkg::SAMPLE_W-1:0]  sample,
    input  logic [lsw_pkg::SAMPLE_W-1:0]  margin_below,
    input  logic [lsw_pkg::SAMPLE_W-1:0]  margin_above,
    output logic                          in_window
);
    import lsw_pkg::*;

    localparam int CAL_LOG = $clog2(CAL_SAMPLES);
    localparam int SHIFT   = SUM_W + CAL_LOG;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] centre_reg, centre_next;
    logic [PROD_W-1:0]   prod;
    logic signed [WIN_W-1:0] lo, hi, smp;

    assign prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};

    always_comb begin
        sum_next    = sum_reg;
        centre_next = centre_reg;
        if (ctrl.divide) begin
            centre_next = prod[SHIFT +: SAMPLE_W];
            sum_next    = '0;
        end else if (ctrl.acc) begin
            sum_next = sum_reg + SUM_W'(sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            centre_reg <= '0;
        end else begin
            sum_reg    <= sum_next;
            centre_reg <= centre_next;
        end
    end

    assign smp = $signed({2'b00, sample});
    assign lo  = $signed({2'b00, centre_reg}) - $signed({2'b00, margin_below});
    assign hi  = $signed({2'b00, centre_reg}) + $signed({2'b00, margin_above});
    assign in_window = (smp > lo) && (smp < hi);

endmodule

FILE: rtl/core/lsw_merge.sv
`timescale 1ns / 1ps
// Merge of the lane flags: drive table lookup and the held drive state.
// Depends on lsw_pkg.
module lsw_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd,
    input  logic [lsw_pkg::CHANNELS-1:0]  flags,
    output lsw_pkg::drive_t               drive_next,
    output logic                          known
);
    import lsw_pkg::*;

    typedef struct packed {
        logic   hit;
        drive_t drive;
    } lookup_t;

    function automatic drive_t run(input logic [DUTY_W-1:0] a, input logic [DUTY_W-1:0] b,
                                   input logic [DUTY_W-1:0] c, input logic [DUTY_W-1:0] d);
        drive_t r;
        r.duty_a    = a;
        r.duty_b    = b;
        r.duty_c    = c;
        r.duty_d    = d;
        r.direction = DRIVE_DIR;
        r.stop      = 1'b0;
        return r;
    endfunction

    function automatic lookup_t lookup(input logic [CHANNELS-1:0] f);
        lookup_t r;
        r.hit   = 1'b1;
        r.drive = DRIVE_STOP;
        case (f) inside
            8'h00, 8'hFF: r.drive = DRIVE_STOP;
            8'h01: r.drive = run(12'd690,  12'd63,   12'd2815, 12'd3065);
            8'h03: r.drive = run(12'd690,  12'd63,   12'd2440, 12'd2815);
            8'h02: r.drive = run(12'd690,  12'd63,   12'd2065, 12'd2440);
            8'h06: r.drive = run(12'd690,  12'd63,   12'd1689, 12'd2065);
            8'h04: r.drive = run(12'd690,  12'd63,   12'd1314, 12'd1089);
            8'h0C: r.drive = run(12'd690,  12'd63,   12'd939,  12'd1314);
            8'h08: r.drive = run(12'd690,  12'd63,   12'd563,  12'd939);
            8'h18: r.drive = run(12'd690,  12'd63,   12'd188,  12'd588);
            8'h10: r.drive = run(12'd1064, 12'd438,  12'd188,  12'd588);
            8'h30: r.drive = run(12'd1314, 12'd814,  12'd188,  12'd588);
            8'h20: r.drive = run(12'd1689, 12'd1189, 12'd188,  12'd588);
            8'h60: r.drive = run(12'd2065, 12'd1564, 12'd188,  12'd588);
            8'h40: r.drive = run(12'd2440, 12'd1940, 12'd188,  12'd588);
            8'hC0: r.drive = run(12'd2815, 12'd2315, 12'd188,  12'd588);
            8'h80: r.drive = run(12'd3065, 12'd2690, 12'd188,  12'd588);
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    lookup_t hit_row;
    drive_t  drive_reg;

    assign hit_row    = lookup(flags);
    assign known      = upd && hit_row.hit;
    assign drive_next = known ? hit_row.drive : drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= DRIVE_STOP;
        end else begin
            drive_reg <= drive_next;
        end
    end

endmodule

FILE: rtl/core/line_sensor_window_drive_top.sv
`timescale 1ns / 1ps
// Top level of the line sensor window drive: eight channel lanes, the drive merge,
// configuration registers and the result register. Depends on lsw_pkg, lsw_lane, lsw_merge.
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_func, s_sample_0 .. s_sample_7
//  m_       out        m_valid / m_ready      m_line_flags, m_duty_a..d, m_direction_bits,
//                                             m_stopped, m_pattern_known, m_calibrated
//  cfg_     in         cfg_wr_en              cfg_wr_index, cfg_wr_data
//
// One transaction per cycle while s_ready; each result appears in the cycle after its input.
// The cycle after the CAL_SAMPLES-th calibration transaction is spent on the
// reciprocal multiply that loads the eight centres; s_ready is low for that cycle.
// Synchronous active-low reset clears sums, centres, count and held drive, and
// loads the margins with their default values.
// A stalled result holds in the output register; s_ready follows m_ready then.
module line_sensor_window_drive_top #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_0,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_1,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_2,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_3,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_4,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_5,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_6,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    s_sample_7,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lsw_pkg::CHANNELS-1:0]    m_line_flags,
    output logic [lsw_pkg::DUTY_W-1:0]      m_duty_a,
    output logic [lsw_pkg::DUTY_W-1:0]      m_duty_b,
    output logic [lsw_pkg::DUTY_W-1:0]      m_duty_c,
    output logic [lsw_pkg::DUTY_W-1:0]      m_duty_d,
    output logic [lsw_pkg::DIR_W-1:0]       m_direction_bits,
    output logic                            m_stopped,
    output logic                            m_pattern_known,
    output logic                            m_calibrated,
    input  logic                            cfg_wr_en,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [lsw_pkg::SAMPLE_W-1:0]    cfg_wr_data
);
    import lsw_pkg::*;

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

    logic [SAMPLE_W-1:0] margin_below_reg, margin_above_reg, margin_above_ch6_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                cal_reg, cal_next;
    logic                div_pend_reg, div_pend_next;
    logic                m_valid_reg, m_valid_next;

    logic [CHANNELS-1:0] flags_reg;
    drive_t              drive_out_reg;
    logic                known_reg;
    logic                cal_out_reg;

    logic                accept, cal_acc, op_acc, cal_last, known;
    logic [SAMPLE_W-1:0] samples [CHANNELS];
    logic [CHANNELS-1:0] flags;
    lane_ctrl_t          lane_ctrl;
    drive_t              drive_next;

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    assign s_ready  = !div_pend_reg && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign cal_acc  = accept && !s_func;
    assign op_acc   = accept && s_func;
    assign cal_last = cal_acc && (cnt_reg == CNT_W'(CAL_SAMPLES - 1));

    assign lane_ctrl.acc    = cal_acc;
    assign lane_ctrl.divide = div_pend_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_below_reg     <= MARGIN_BELOW_RST;
            margin_above_reg     <= MARGIN_ABOVE_RST;
            margin_above_ch6_reg <= MARGIN_ABOVE_CH6_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MARGIN_BELOW:     margin_below_reg     <= cfg_wr_data;
                REG_MARGIN_ABOVE:     margin_above_reg     <= cfg_wr_data;
                REG_MARGIN_ABOVE_CH6: margin_above_ch6_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_lane
        logic [SAMPLE_W-1:0] upper;
        if (gi == CH6_IDX) begin : g_ch6
            assign upper = margin_above_ch6_reg;
        end else begin : g_std
            assign upper = margin_above_reg;
        end
        lsw_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (lane_ctrl),
            .sample       (samples[gi]),
            .margin_below (margin_below_reg),
            .margin_above (upper),
            .in_window    (flags[gi])
        );
    end

    lsw_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (op_acc),
        .flags      (flags),
        .drive_next (drive_next),
        .known      (known)
    );

    always_comb begin
        cnt_next      = cnt_reg;
        cal_next      = cal_reg;
        div_pend_next = cal_last;
        m_valid_next  = m_valid_reg;
        if (cal_acc) begin
            cnt_next = cal_last ? '0 : cnt_reg + CNT_W'(1);
        end
        if (cal_last) begin
            cal_next = 1'b1;
        end
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            cal_reg      <= 1'b0;
            div_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            cal_reg      <= cal_next;
            div_pend_reg <= div_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            flags_reg     <= s_func ? flags : '0;
            drive_out_reg <= drive_next;
            known_reg     <= known;
            cal_out_reg   <= cal_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_flags     = flags_reg;
    assign m_duty_a         = drive_out_reg.duty_a;
    assign m_duty_b         = drive_out_reg.duty_b;
    assign m_duty_c         = drive_out_reg.duty_c;
    assign m_duty_d         = drive_out_reg.duty_d;
    assign m_direction_bits = drive_out_reg.direction;
    assign m_stopped        = drive_out_reg.stop;
    assign m_pattern_known  = known_reg;
    assign m_calibrated     = cal_out_reg;

endmodule

FILE: rtl/core/lsw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the line sensor window drive and its bind to the top level.
// Depends on lsw_pkg and line_sensor_window_drive_top_macros.svh.
`include "line_sensor_window_drive_top_macros.svh"

module lsw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lsw_pkg::CHANNELS-1:0]    m_line_flags,
    input logic [lsw_pkg::DUTY_W-1:0]      m_duty_a,
    input logic [lsw_pkg::DUTY_W-1:0]      m_duty_b,
    input logic [lsw_pkg::DUTY_W-1:0]      m_duty_c,
    input logic [lsw_pkg::DUTY_W-1:0]      m_duty_d,
    input logic [lsw_pkg::DIR_W-1:0]       m_direction_bits,
    input logic                            m_stopped,
    input logic                            m_pattern_known,
    input logic                            m_calibrated
);
    import lsw_pkg::*;

    `LSW_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_valid,
        "result valid after reset")

    `LSW_ASSERT(a_stall_holds, m_valid && !m_ready |=>
        m_valid && $stable(m_line_flags) && $stable(m_duty_a) && $stable(m_pattern_known),
        "stalled result changed")

    `LSW_ASSERT(a_drive_consistent, m_valid |->
        (m_stopped && m_duty_a == '0 && m_duty_b == '0 && m_duty_c == '0 &&
         m_duty_d == '0 && m_direction_bits == STOP_DIR) ||
        (!m_stopped && m_direction_bits == DRIVE_DIR),
        "drive fields disagree with stop state")

    `LSW_ASSERT(a_stop_pattern, m_valid && m_pattern_known &&
        (m_line_flags == '0 || m_line_flags == '1) |-> m_stopped,
        "stop pattern did not stop the motors")

    `LSW_ASSERT(a_calibrated_sticky, m_valid && m_calibrated |=> !m_valid || m_calibrated,
        "calibrated flag dropped")

endmodule

bind line_sensor_window_drive_top lsw_checker u_lsw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_line_flags     (m_line_flags),
    .m_duty_a         (m_duty_a),
    .m_duty_b         (m_duty_b),
    .m_duty_c         (m_duty_c),
    .m_duty_d         (m_duty_d),
    .m_direction_bits (m_direction_bits),
    .m_stopped        (m_stopped),
    .m_pattern_known  (m_pattern_known),
    .m_calibrated     (m_calibrated)
);
